// ===== design/paired_read_duplicate_marker_core_assert.svh =====
// Assertion macros shared by the duplicate marker block.
`ifndef PAIRED_READ_DUPLICATE_MARKER_CORE_ASSERT_SVH
`define PAIRED_READ_DUPLICATE_MARKER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pdm_pkg.sv =====
`default_nettype none
package pdm_pkg;

    localparam int unsigned KeyWidth   = 64;
    localparam int unsigned ChromWidth = 8;
    localparam int unsigned PairWidth  = 32;
    localparam int unsigned ScoreWidth = 24;
    localparam int unsigned EntryWidth = KeyWidth + ChromWidth + PairWidth + ScoreWidth;

    typedef enum logic [2:0] {
        t_verdict_new       = 3'd0,
        t_verdict_dup_this  = 3'd1,
        t_verdict_dup_prior = 3'd2,
        t_verdict_discard   = 3'd3,
        t_verdict_full      = 3'd4
    } t_verdict;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     next;
        logic     wr_upd;
        logic     wr_new;
        logic     set_verdict;
        t_verdict verdict;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic discard;
        logic used_zero;
        logic match;
        logic score_ge;
        logic last;
        logic full;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/pdm_ram.sv =====
`default_nettype none
module pdm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== design/pdm_ctrl.sv =====
`default_nettype none
module pdm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire pdm_pkg::t_sts i_sts,
    output pdm_pkg::t_cmd      o_cmd,
    output logic               o_in_ready
);

    pdm_pkg::t_state r_state;
    pdm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pdm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pdm_pkg::S_CHECK;
            end
            pdm_pkg::S_CHECK: begin
                if (i_sts.discard || i_sts.used_zero) n_state = pdm_pkg::S_FIN;
                else n_state = pdm_pkg::S_READ;
            end
            pdm_pkg::S_READ: begin
                n_state = pdm_pkg::S_CMP;
            end
            pdm_pkg::S_CMP: begin
                if (i_sts.match || i_sts.last) n_state = pdm_pkg::S_FIN;
                else n_state = pdm_pkg::S_READ;
            end
            pdm_pkg::S_FIN: begin
                if (i_sts.out_free) n_state = pdm_pkg::S_IDLE;
            end
            default: n_state = pdm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.verdict = pdm_pkg::t_verdict_new;
        o_in_ready = 1'b0;
        case (r_state)
            pdm_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            pdm_pkg::S_CHECK: begin
                if (i_sts.discard) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = pdm_pkg::t_verdict_discard;
                end else if (i_sts.used_zero) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.wr_new      = 1'b1;
                    o_cmd.verdict     = pdm_pkg::t_verdict_new;
                end
            end
            pdm_pkg::S_CMP: begin
                if (i_sts.match) begin
                    o_cmd.set_verdict = 1'b1;
                    if (i_sts.score_ge) begin
                        o_cmd.verdict = pdm_pkg::t_verdict_dup_this;
                    end else begin
                        o_cmd.verdict = pdm_pkg::t_verdict_dup_prior;
                        o_cmd.wr_upd  = 1'b1;
                    end
                end else if (i_sts.last) begin
                    o_cmd.set_verdict = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.verdict = pdm_pkg::t_verdict_full;
                    end else begin
                        o_cmd.verdict = pdm_pkg::t_verdict_new;
                        o_cmd.wr_new  = 1'b1;
                    end
                end else begin
                    o_cmd.next = 1'b1;
                end
            end
            pdm_pkg::S_FIN: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/pdm_dp.sv =====
`default_nettype none
module pdm_dp #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pdm_pkg::t_cmd i_cmd,
    output pdm_pkg::t_sts      o_sts,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [8:0]    i_cfg_wr_data,
    input  wire logic [111:0]  i_in_data,
    input  wire logic          i_in_fwd,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [95:0]        o_out_data,
    output logic [2:0]         o_out_verdict
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam logic [AW:0] DepthVal = TABLE_DEPTH[AW:0];

    logic [8:0]  r_chrom_count;
    logic [7:0]  r_chrom;
    logic [31:0] r_left;
    logic [31:0] r_frag;
    logic        r_fwd;
    logic [23:0] r_score;
    logic [31:0] r_cnt;
    logic [AW:0] r_used;
    logic [AW:0] r_idx;
    pdm_pkg::t_verdict r_verdict;
    logic [31:0] r_dup;
    logic        r_ov;
    logic [95:0] r_odata;
    logic [2:0]  r_overd;

    logic [31:0] in_first, in_second, in_left, in_right;
    logic [15:0] in_len;
    logic [31:0] key_low;
    logic [63:0] key;
    logic [pdm_pkg::EntryWidth-1:0] wdata, rdata;
    logic [AW-1:0] waddr;
    logic [AW:0]   idx_inc;

    assign in_first  = i_in_data[39:8];
    assign in_second = i_in_data[71:40];
    assign in_len    = i_in_data[87:72];
    assign in_left   = i_in_fwd ? in_first : in_second;
    assign in_right  = i_in_fwd ? in_second : in_first;

    assign key_low = r_fwd ? r_frag : (32'd0 - r_frag);
    assign key     = {r_left, key_low};
    assign wdata   = {r_score, r_cnt, r_chrom, key};
    assign waddr   = i_cmd.wr_upd ? r_idx[AW-1:0] : r_used[AW-1:0];
    assign idx_inc = r_idx + 1'b1;

    pdm_ram #(
        .WIDTH(pdm_pkg::EntryWidth),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_upd | i_cmd.wr_new),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(rdata)
    );

    always_comb begin
        o_sts.discard   = {1'b0, r_chrom} >= r_chrom_count;
        o_sts.used_zero = r_used == '0;
        o_sts.match     = (rdata[71:64] == r_chrom) && (rdata[63:0] == key);
        o_sts.score_ge  = rdata[127:104] >= r_score;
        o_sts.last      = idx_inc == r_used;
        o_sts.full      = r_used == DepthVal;
        o_sts.out_free  = !r_ov || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chrom_count <= '0;
            r_cnt         <= '0;
            r_used        <= '0;
            r_idx         <= '0;
            r_ov          <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_chrom_count <= i_cfg_wr_data;
            if (i_cmd.accept) begin
                r_cnt <= r_cnt + 32'd1;
                r_idx <= '0;
            end else if (i_cmd.next) begin
                r_idx <= idx_inc;
            end
            if (i_cmd.wr_new) r_used <= r_used + 1'b1;
            if (i_cmd.out_load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_chrom <= i_in_data[7:0];
            r_left  <= in_left;
            r_frag  <= in_right + {16'd0, in_len} - in_left;
            r_fwd   <= i_in_fwd;
            r_score <= i_in_data[111:88];
        end
        if (i_cmd.set_verdict) begin
            r_verdict <= i_cmd.verdict;
            case (i_cmd.verdict)
                pdm_pkg::t_verdict_dup_this:  r_dup <= r_cnt;
                pdm_pkg::t_verdict_dup_prior: r_dup <= rdata[103:72];
                default:                      r_dup <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_overd <= r_verdict;
            if (r_verdict == pdm_pkg::t_verdict_discard) begin
                r_odata <= {32'd0, 32'd0, r_cnt};
            end else begin
                r_odata <= {r_frag, r_dup, r_cnt};
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_data    = r_odata;
    assign o_out_verdict = r_overd;

endmodule
`default_nettype wire

// ===== design/paired_read_duplicate_marker_core.sv =====
// Paired-read duplicate marker. Each slave-side transfer carries one aligned
// read pair; each master-side transfer carries its verdict. Pairs are numbered
// from 1 in arrival order, discarded pairs included.
// The input channel is taken in the idle state only, so one pair is worked on
// at a time. A pair is checked against chromosome_count, then the table is
// scanned linearly from entry 0: each stored entry passes a read state and a
// compare state on the single table memory; a match ends the scan early.
// New keys fill the table in order, so a fill count marks the valid entries.
// The result lands in an output register. The next pair is accepted while a
// result waits; a stalled receiver only holds the block in its final state
// until the output register frees.
// Reset (synchronous, active low) empties the table at once, clears the pair
// counter and sets chromosome_count to 0, so every pair is discarded until
// the register is written. The register is to be written only while idle;
// the block itself does not enforce this.
`default_nettype none
`include "paired_read_duplicate_marker_core_assert.svh"
module paired_read_duplicate_marker_core #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [8:0]   i_cfg_wr_data,  // chromosome_count
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // chromosome_index[7:0], first_position[39:8], second_position[71:40],
    // end_mate_length[87:72], quality_sum[111:88]
    input  wire logic [111:0] s_axis_tdata,
    input  wire logic         s_axis_tuser,   // forward_conversion
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pair_number[31:0], duplicate_pair[63:32], fragment_size[95:64]
    output logic [95:0]       m_axis_tdata,
    output logic [2:0]        m_axis_tuser    // verdict
);

    // Commands from the controller and status back from the datapath.
    pdm_pkg::t_cmd cmd;
    pdm_pkg::t_sts sts;

    pdm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_in_ready(s_axis_tready)
    );

    pdm_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_data    (s_axis_tdata),
        .i_in_fwd     (s_axis_tuser),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_verdict(m_axis_tuser)
    );

    // A result is never loaded over one that the receiver has not taken.
    `PDM_ASSERT_NOW(a_out_no_overwrite, i_clk, i_rst_n, cmd.out_load, (!m_axis_tvalid || m_axis_tready), "result overwritten")
    // After an accepted transfer the block is busy with that pair.
    `PDM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, (i_rst_n && s_axis_tvalid && s_axis_tready), !s_axis_tready, "accepted while busy")
    // A new entry is only stored while the table has room.
    `PDM_ASSERT_NOW(a_no_write_when_full, i_clk, i_rst_n, cmd.wr_new, !sts.full, "write into full table")

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none
module tb_top;
    import pdm_pkg::*;

    localparam int unsigned DEPTH = 1024;

    // One predicted result transfer: what the block should report for one pair.
    typedef struct {
        logic [31:0] pair_number;
        t_verdict    verdict;
        logic [31:0] duplicate_pair;
        logic [31:0] fragment_size;
    } t_marking;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [8:0]    i_cfg_wr_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    // chromosome_index, first_position, second_position, end_mate_length,
    // quality_sum (lowest bits first)
    logic [111:0]  s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;   // forward_conversion
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // pair_number, duplicate_pair, fragment_size (lowest bits first)
    logic [95:0]   m_axis_tdata;
    logic [2:0]    m_axis_tuser;          // verdict

    paired_read_duplicate_marker_core #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Scoreboard state.
    t_marking    pending_markings[$];
    int          error_count = 0;
    int          markings_seen = 0;
    int          verdict_tally[5];

    // Our own copy of the duplicate table, the pair counter and the register.
    logic [63:0] dup_key[DEPTH];
    logic [7:0]  dup_chrom[DEPTH];
    logic [31:0] dup_pair[DEPTH];
    logic [23:0] dup_score[DEPTH];
    int          dup_used = 0;
    logic [31:0] pairs_numbered = '0;
    logic [8:0]  known_chroms = '0;

    // Sender and receiver pacing controls.
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    logic        hold_kick = 1'b0;

    // Pool of locations that the random part keeps revisiting, so that most
    // pairs hit stored keys instead of growing the table.
    logic [7:0]  loc_chrom[40];
    logic [31:0] loc_left[40];
    logic [31:0] loc_low[40];

    // Works out the marking of one accepted pair and updates the table copy.
    function automatic t_marking mark_pair(input logic [7:0] chrom, input logic [31:0] first,
                                           input logic [31:0] second, input logic [15:0] len,
                                           input logic fwd, input logic [23:0] score);
        t_marking    m;
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] frag;
        logic [63:0] key;
        int          hit;
        pairs_numbered = pairs_numbered + 32'd1;
        m.pair_number = pairs_numbered;
        m.duplicate_pair = '0;
        m.fragment_size = '0;
        m.verdict = t_verdict_discard;
        if ({1'b0, chrom} >= known_chroms) begin
            return m;
        end
        left = fwd ? first : second;
        right = fwd ? second : first;
        frag = right + {16'd0, len} - left;
        key = {left, fwd ? frag : (32'd0 - frag)};
        m.fragment_size = frag;
        hit = -1;
        for (int i = 0; i < dup_used; i++) begin
            if (hit < 0 && dup_chrom[i] == chrom && dup_key[i] == key) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            if (dup_score[hit] >= score) begin
                m.verdict = t_verdict_dup_this;
                m.duplicate_pair = pairs_numbered;
            end else begin
                m.verdict = t_verdict_dup_prior;
                m.duplicate_pair = dup_pair[hit];
                dup_pair[hit] = pairs_numbered;
                dup_score[hit] = score;
            end
        end else if (dup_used < DEPTH) begin
            dup_key[dup_used] = key;
            dup_chrom[dup_used] = chrom;
            dup_pair[dup_used] = pairs_numbered;
            dup_score[dup_used] = score;
            dup_used++;
            m.verdict = t_verdict_new;
        end else begin
            m.verdict = t_verdict_full;
        end
        return m;
    endfunction

    // Offers one pair after a random gap and waits for its transfer. The valid
    // stays high afterwards; whoever waits next lowers it in that same step.
    task automatic send_pair(input logic [7:0] chrom, input logic [31:0] first,
                             input logic [31:0] second, input logic [15:0] len,
                             input logic fwd, input logic [23:0] score);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {score, len, second, first, chrom};
        s_axis_tuser <= fwd;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_markings.push_back(mark_pair(chrom, first, second, len, fwd, score));
    endtask

    // Sends a pair at a stored location with the given key low word. The
    // strand is random; the reverse form uses the negated size so that both
    // forms land on the same key, and right and length vary freely.
    task automatic send_at_location(input logic [7:0] chrom, input logic [31:0] left,
                                    input logic [31:0] low, input logic [23:0] score);
        logic        fwd;
        logic [15:0] len;
        logic [31:0] frag;
        logic [31:0] right;
        fwd = 1'($urandom_range(0, 1));
        len = 16'($urandom);
        frag = fwd ? low : (32'd0 - low);
        right = left + frag - {16'd0, len};
        if (fwd) begin
            send_pair(chrom, left, right, len, fwd, score);
        end else begin
            send_pair(chrom, right, left, len, fwd, score);
        end
    endtask

    task automatic send_noise();
        send_pair(8'($urandom), $urandom, $urandom, 16'($urandom),
                  1'($urandom_range(0, 1)), 24'($urandom));
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_markings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_chrom_count(input logic [8:0] count);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= count;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        known_chroms = count;
        @(posedge i_clk);
    endtask

    // Receiver: checks each result transfer against the oldest prediction and
    // draws a random stall per transfer. A toggle of hold_kick
    // starts a long hold-off counted here.
    always @(posedge i_clk) begin
        static int rx_wait = 0;
        static int hold_left = 0;
        static logic hold_ack = 1'b0;
        t_marking want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            markings_seen++;
            if (m_axis_tuser <= 3'd4) begin
                verdict_tally[m_axis_tuser]++;
            end
            if (pending_markings.size() == 0) begin
                $display("%0t: unexpected result pair %0d verdict %0d", $time,
                         m_axis_tdata[31:0], m_axis_tuser);
                error_count++;
            end else begin
                want = pending_markings.pop_front();
                if (m_axis_tdata[31:0] !== want.pair_number) begin
                    $display("%0t: pair_number expected %0d actual %0d", $time,
                             want.pair_number, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tuser !== want.verdict) begin
                    $display("%0t: verdict of pair %0d expected %0d actual %0d", $time,
                             want.pair_number, want.verdict, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[63:32] !== want.duplicate_pair) begin
                    $display("%0t: duplicate_pair of pair %0d expected %0d actual %0d",
                             $time, want.pair_number, want.duplicate_pair,
                             m_axis_tdata[63:32]);
                    error_count++;
                end
                if (m_axis_tdata[95:64] !== want.fragment_size) begin
                    $display("%0t: fragment_size of pair %0d expected %h actual %h", $time,
                             want.pair_number, want.fragment_size, m_axis_tdata[95:64]);
                    error_count++;
                end
            end
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 3);
        end
        if (hold_kick != hold_ack) begin
            hold_ack = hold_kick;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Right after reset the register is 0, so every pair is discarded.
    task automatic test_discard_after_reset();
        send_pair(8'd0, 32'd100, 32'd200, 16'd50, 1'b1, 24'd10);
        send_pair(8'd255, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 1'b0, 24'hFF_FFFF);
        send_noise();
        send_noise();
    endtask

    // Field extremes, every verdict but the table-full one, ties, both strand
    // forms of one key and the register at its bounds and above 256.
    task automatic test_extremes();
        write_chrom_count(9'd256);
        send_pair(8'd255, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 24'd0);
        send_pair(8'd255, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 24'd0);
        send_pair(8'd255, 32'd0, 32'hFFFF_0000, 16'h0000, 1'b1, 24'hFF_FFFF);
        send_pair(8'd255, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 24'hFF_FFFF);
        send_pair(8'd0, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0, 24'hFF_FFFF);
        send_pair(8'd1, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0, 24'd5);
        send_pair(8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 1'b1, 24'd7);
        // The reverse form of the key stored just before, first with a lower and
        // then with a higher score.
        send_at_location(8'd7, 32'h1234_5678, 32'd300, 24'd1000);
        send_pair(8'd7, 32'h1234_5678 - 32'd300 - 32'd20, 32'h1234_5678, 16'd20, 1'b0,
                  24'd999);
        send_pair(8'd7, 32'h1234_5678 - 32'd300 - 32'd20, 32'h1234_5678, 16'd20, 1'b0,
                  24'd1001);
        write_chrom_count(9'd300);
        send_pair(8'd255, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 24'd3);
        send_noise();
        write_chrom_count(9'd511);
        send_pair(8'd128, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 1'b0, 24'h80_0000);
        write_chrom_count(9'd1);
        send_pair(8'd1, 32'd5, 32'd6, 16'd1, 1'b1, 24'd1);
        send_pair(8'd0, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0, 24'hFF_FFFE);
    endtask

    // Random pairs, mostly revisiting a pool of locations with random scores
    // and strand forms, the rest random noise.
    task automatic run_pool_traffic(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 82) begin
                pick = $urandom_range(0, 39);
                send_at_location(loc_chrom[pick], loc_left[pick], loc_low[pick],
                                 $urandom_range(0, 15) == 0 ? 24'd0 : 24'($urandom));
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic test_random_traffic();
        write_chrom_count(9'd40);
        for (int i = 0; i < 40; i++) begin
            loc_chrom[i] = 8'($urandom_range(0, 39));
            loc_left[i] = $urandom;
            loc_low[i] = $urandom;
        end
        run_pool_traffic(150);
        // A stretch with no idling on either side.
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_pool_traffic(60);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        write_chrom_count(9'd20);
        run_pool_traffic(120);
        write_chrom_count(9'd256);
        run_pool_traffic(70);
    endtask

    // The receiver holds off for a long stretch while pairs keep coming, so
    // the block fills up and stalls its input; then the sender waits it out.
    task automatic test_backpressure();
        hold_kick <= ~hold_kick;
        run_pool_traffic(12);
        drain();
    endtask

    // Fills the table with new keys, then checks the table-full verdict next
    // to matches and discards on a full table.
    task automatic test_table_full();
        int pick;
        write_chrom_count(9'd256);
        while (dup_used < DEPTH) begin
            send_noise();
        end
        for (int i = 0; i < 8; i++) begin
            send_noise();
        end
        for (int i = 0; i < 6; i++) begin
            pick = $urandom_range(0, 39);
            send_at_location(loc_chrom[pick], loc_left[pick], loc_low[pick],
                             24'($urandom));
        end
        write_chrom_count(9'd0);
        send_noise();
        send_noise();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_discard_after_reset();
        test_extremes();
        test_random_traffic();
        test_backpressure();
        test_table_full();
        drain();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d pairs: %0d new, %0d duplicates, %0d displaced, %0d discarded,",
                 markings_seen, verdict_tally[0], verdict_tally[1], verdict_tally[2],
                 verdict_tally[3]);
        $display("%0d on a full table, over register settings 0, 1, 20, 40, 256, 300, 511.",
                 verdict_tally[4]);
        if (error_count == 0 && pending_markings.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Timed out with %0d results outstanding.", pending_markings.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
